[rtl/core/crfc_pkg.sv]
// Shared types, constants and helper functions of the LED ring frame composer.
`timescale 1ns / 1ps

package crfc_pkg;

  // Ring geometry
  localparam int RING_LEDS       = 60;
  localparam int LED_W           = 6;
  localparam int QUARTER_STEP    = 15;
  localparam int FIVE_STEP       = 5;
  localparam int HOURS_PER_FACE  = 12;
  localparam int HOUR_MAX        = 23;
  localparam int MINUTE_MAX      = 59;
  localparam logic [LED_W-1:0] LAST_LED = LED_W'(RING_LEDS - 1);

  // Hand spread limit, valid range 1 to 7
  localparam int HAND_HALF_WIDTH = 4;
  localparam int SPREAD_W        = 3;
  localparam int SPREAD_FIELD_W  = 2 * SPREAD_W;
  // Divisor codes run up to HAND_HALF_WIDTH + 1
  localparam int DIST_W          = $clog2(HAND_HALF_WIDTH + 2);

  // Data widths
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int SPREADS_W  = 18;
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int PROD_W     = CH_W + RECIP_W;
  localparam int CFG_IDX_W  = 3;

  // Hand slots: same order as the spread fields
  localparam int NUM_HANDS  = 3;
  localparam int HAND_SEC   = 0;
  localparam int HAND_MIN   = 1;
  localparam int HAND_HOUR  = 2;

  // Minute to hour-step: m / 12 as (m * 43) >> 9, exact for m up to 59
  localparam int MIN12_MUL  = 43;
  localparam int MIN12_SH   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEC_COLOR     = 3'd0,
    CFG_MIN_COLOR     = 3'd1,
    CFG_HOUR_COLOR    = 3'd2,
    CFG_SPREADS       = 3'd3,
    CFG_FIVE_COLOR    = 3'd4,
    CFG_QUARTER_COLOR = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_FIVE,
    MARK_QUARTER
  } mark_t;

  typedef struct packed {
    logic [4:0]       hour;
    logic [LED_W-1:0] minute;
    logic [LED_W-1:0] second;
  } in_t;

  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   sec_color;
    logic [COLOR_W-1:0]   min_color;
    logic [COLOR_W-1:0]   hour_color;
    logic [SPREADS_W-1:0] spreads;
    logic [COLOR_W-1:0]   five_color;
    logic [COLOR_W-1:0]   quarter_color;
  } cfg_t;

  // Sequencer stage: one LED of the frame
  typedef struct packed {
    logic                              valid;
    logic [LED_W-1:0]                  led;
    logic                              last;
    mark_t                             mark;
    logic [NUM_HANDS-1:0][LED_W-1:0]   centre;
  } s0_t;

  // Locate stage: per-hand reciprocal of the divisor, zero when the hand misses
  typedef struct packed {
    logic                              valid;
    logic [LED_W-1:0]                  led;
    logic                              last;
    mark_t                             mark;
    logic [NUM_HANDS-1:0][RECIP_W-1:0] recip;
  } s1_t;

  // Scale stage: per-hand scaled color
  typedef struct packed {
    logic                              valid;
    logic [LED_W-1:0]                  led;
    logic                              last;
    mark_t                             mark;
    logic [NUM_HANDS-1:0][COLOR_W-1:0] color;
  } s2_t;

  // Limit a 3-bit spread to the hand half width
  function automatic logic [SPREAD_W-1:0] clamp_spread(input logic [SPREAD_W-1:0] v);
    logic [SPREAD_W-1:0] r;
    r = v;
    if (v > SPREAD_W'(HAND_HALF_WIDTH)) r = SPREAD_W'(HAND_HALF_WIDTH);
    return r;
  endfunction

  // ceil(2^16 / d): (v * recip) >> 16 equals v / d for any 8-bit v
  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/crfc_seq.sv]
// Frame sequencer: takes a time and issues LED positions 0 to 59, one per cycle while adv is high.
`timescale 1ns / 1ps

module crfc_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  output logic          in_ready,
  input  crfc_pkg::in_t in_data,
  output crfc_pkg::s0_t s0
);
  import crfc_pkg::*;

  logic                             busy_r, busy_nxt;
  logic [LED_W-1:0]                 cnt_r, cnt_nxt;
  logic [2:0]                       ph5_r, ph5_nxt;
  logic [NUM_HANDS-1:0][LED_W-1:0]  centre_r, centre_nxt;

  logic             accept;
  logic             at_last;
  logic [4:0]       hour_sat;
  logic [3:0]       hour12;
  logic [LED_W-1:0] min_sat;
  logic [LED_W-1:0] sec_sat;
  logic [11:0]      min_prod;
  logic [2:0]       min_step;
  logic [LED_W-1:0] hour_pos;

  assign at_last  = (cnt_r == LAST_LED);
  assign in_ready = adv && (!busy_r || at_last);
  assign accept   = in_valid && in_ready;

  // Saturate the time and place the hour hand
  always_comb begin
    hour_sat = (in_data.hour > 5'(HOUR_MAX)) ? 5'(HOUR_MAX) : in_data.hour;
    min_sat  = (in_data.minute > LED_W'(MINUTE_MAX)) ? LED_W'(MINUTE_MAX) : in_data.minute;
    sec_sat  = (in_data.second > LED_W'(MINUTE_MAX)) ? LED_W'(MINUTE_MAX) : in_data.second;
    hour12   = (hour_sat >= 5'(HOURS_PER_FACE)) ? 4'(hour_sat - 5'(HOURS_PER_FACE))
                                                : 4'(hour_sat);
    min_prod = 12'(min_sat) * 12'(MIN12_MUL);
    min_step = 3'(min_prod >> MIN12_SH);
    hour_pos = LED_W'({hour12, 2'b00}) + LED_W'(hour12) + LED_W'(min_step);
  end

  // Advance the LED counter, load a new frame on accept
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    ph5_nxt    = ph5_r;
    centre_nxt = centre_r;
    if (accept) begin
      busy_nxt             = 1'b1;
      cnt_nxt              = '0;
      ph5_nxt              = '0;
      centre_nxt[HAND_SEC]  = sec_sat;
      centre_nxt[HAND_MIN]  = min_sat;
      centre_nxt[HAND_HOUR] = hour_pos;
    end else if (adv && busy_r) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        ph5_nxt = (ph5_r == 3'(FIVE_STEP - 1)) ? 3'd0 : ph5_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r    <= cnt_nxt;
    ph5_r    <= ph5_nxt;
    centre_r <= centre_nxt;
  end

  // Present the current LED with its marker class
  always_comb begin
    s0.valid  = busy_r;
    s0.led    = cnt_r;
    s0.last   = at_last;
    s0.centre = centre_r;
    if (cnt_r == '0 || cnt_r == LED_W'(QUARTER_STEP) ||
        cnt_r == LED_W'(2 * QUARTER_STEP) || cnt_r == LED_W'(3 * QUARTER_STEP)) begin
      s0.mark = MARK_QUARTER;
    end else if (ph5_r == '0) begin
      s0.mark = MARK_FIVE;
    end else begin
      s0.mark = MARK_NONE;
    end
  end

endmodule

[rtl/core/crfc_locate.sv]
// Locate stage: finds each hand's distance to the LED and picks the divisor.
`timescale 1ns / 1ps

module crfc_locate (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  crfc_pkg::cfg_t cfg,
  input  crfc_pkg::s0_t  s0,
  output crfc_pkg::s1_t  s1
);
  import crfc_pkg::*;

  s1_t s1_r, s1_nxt;

  always_comb begin
    logic [LED_W:0]      sum;
    logic [LED_W-1:0]    diff;
    logic [LED_W-1:0]    bdist;
    logic [SPREAD_W-1:0] sp_before;
    logic [SPREAD_W-1:0] sp_after;
    s1_nxt.valid = s0.valid;
    s1_nxt.led   = s0.led;
    s1_nxt.last  = s0.last;
    s1_nxt.mark  = s0.mark;
    for (int h = 0; h < NUM_HANDS; h++) begin
      sp_before = clamp_spread(cfg.spreads[h*SPREAD_FIELD_W +: SPREAD_W]);
      sp_after  = clamp_spread(cfg.spreads[h*SPREAD_FIELD_W + SPREAD_W +: SPREAD_W]);
      // Ring distance from centre to this LED, going forward
      sum = {1'b0, s0.led} + (LED_W+1)'(RING_LEDS) - {1'b0, s0.centre[h]};
      diff = (sum >= (LED_W+1)'(RING_LEDS)) ? LED_W'(sum - (LED_W+1)'(RING_LEDS))
                                            : LED_W'(sum);
      bdist = LED_W'(RING_LEDS) - diff;
      if (diff == '0) begin
        s1_nxt.recip[h] = recip_of(4'd1);
      end else if (diff <= LED_W'(sp_after)) begin
        s1_nxt.recip[h] = recip_of(4'(diff + 1'b1));
      end else if (bdist <= LED_W'(sp_before)) begin
        s1_nxt.recip[h] = recip_of(4'(bdist));
      end else begin
        s1_nxt.recip[h] = '0;
      end
    end
  end

  // Hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= s1_nxt.valid;
    end
    if (adv) begin
      s1_r.led   <= s1_nxt.led;
      s1_r.last  <= s1_nxt.last;
      s1_r.mark  <= s1_nxt.mark;
      s1_r.recip <= s1_nxt.recip;
    end
  end

  assign s1 = s1_r;

endmodule

[rtl/core/crfc_scale.sv]
// Scale stage: divides each hand color by its divisor through reciprocal multiplies.
`timescale 1ns / 1ps

module crfc_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  crfc_pkg::cfg_t cfg,
  input  crfc_pkg::s1_t  s1,
  output crfc_pkg::s2_t  s2
);
  import crfc_pkg::*;

  s2_t s2_r, s2_nxt;
  logic [NUM_HANDS-1:0][COLOR_W-1:0] hand_color;

  assign hand_color[HAND_SEC]  = cfg.sec_color;
  assign hand_color[HAND_MIN]  = cfg.min_color;
  assign hand_color[HAND_HOUR] = cfg.hour_color;

  always_comb begin
    logic [PROD_W-1:0] prod;
    s2_nxt.valid = s1.valid;
    s2_nxt.led   = s1.led;
    s2_nxt.last  = s1.last;
    s2_nxt.mark  = s1.mark;
    for (int h = 0; h < NUM_HANDS; h++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod = PROD_W'(hand_color[h][c*CH_W +: CH_W]) * PROD_W'(s1.recip[h]);
        s2_nxt.color[h][c*CH_W +: CH_W] = prod[RECIP_SH +: CH_W];
      end
    end
  end

  // Hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r.valid <= s2_nxt.valid;
    end
    if (adv) begin
      s2_r.led   <= s2_nxt.led;
      s2_r.last  <= s2_nxt.last;
      s2_r.mark  <= s2_nxt.mark;
      s2_r.color <= s2_nxt.color;
    end
  end

  assign s2 = s2_r;

endmodule

[rtl/core/clock_ring_frame_composer.sv]
// Top level of the LED ring frame composer: config registers, pipeline and output merge.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data): one time of day per transaction.
//   Result channel (out_valid/out_ready/out_data): 60 transactions per time, one per
//   ring LED in order 0 to 59, carrying led_index, red, green, blue and last (set on 59).
//   Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes; write only
//   while no frame is in flight.
// Path: LED 0 goes from the sequencer via the locate and scale registers to out_data.
// Throughput: one LED per cycle unless stalled. The sequencer counter sets this;
//   the next time is accepted in the cycle LED 59 of the current frame is issued.
// Pipeline: sequencer, locate (distance and divisor), scale (reciprocal multiply),
//   merge into the output register. All stages advance together when the output
//   register is empty or being taken.
// Stall: when out_ready is low with a result held, every stage holds; no LED is lost
//   or repeated, and in_ready drops.
// Reset: rst_n is synchronous, active low; clears all valid bits and loads the default
//   hand and marker colors and spreads.
module clock_ring_frame_composer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  crfc_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output crfc_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [crfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crfc_pkg::COLOR_W-1:0]         cfg_data
);
  import crfc_pkg::*;

  cfg_t cfg_r;
  s0_t  s0;
  s1_t  s1;
  s2_t  s2;
  logic adv;
  logic out_valid_r;
  out_t out_r, out_nxt;

  // Advance the whole pipeline when the output register frees up
  assign adv = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sec_color     <= 24'h0A0000;
      cfg_r.min_color     <= 24'h000A00;
      cfg_r.hour_color    <= 24'h00000F;
      cfg_r.spreads       <= 18'd74304;
      cfg_r.five_color    <= 24'h010101;
      cfg_r.quarter_color <= 24'h020200;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SEC_COLOR:     cfg_r.sec_color     <= cfg_data;
        CFG_MIN_COLOR:     cfg_r.min_color     <= cfg_data;
        CFG_HOUR_COLOR:    cfg_r.hour_color    <= cfg_data;
        CFG_SPREADS:       cfg_r.spreads       <= cfg_data[SPREADS_W-1:0];
        CFG_FIVE_COLOR:    cfg_r.five_color    <= cfg_data;
        CFG_QUARTER_COLOR: cfg_r.quarter_color <= cfg_data;
        default: ;
      endcase
    end
  end

  crfc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s0       (s0)
  );

  crfc_locate u_locate (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .s0    (s0),
    .s1    (s1)
  );

  crfc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .s1    (s1),
    .s2    (s2)
  );

  // Merge markers and hands into one color
  always_comb begin
    logic [COLOR_W-1:0] rgb;
    unique case (s2.mark)
      MARK_QUARTER: rgb = cfg_r.quarter_color;
      MARK_FIVE:    rgb = cfg_r.five_color;
      default:      rgb = '0;
    endcase
    for (int h = 0; h < NUM_HANDS; h++) begin
      rgb = rgb | s2.color[h];
    end
    out_nxt.led_index = s2.led;
    out_nxt.red       = rgb[2*CH_W +: CH_W];
    out_nxt.green     = rgb[CH_W +: CH_W];
    out_nxt.blue      = rgb[0 +: CH_W];
    out_nxt.last      = s2.last;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2.valid;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // The flagged LED is always the last ring position
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.led_index == LAST_LED)
    else $error("last flag on wrong LED");

  // Inside a frame the next LED follows at once
  a_frame_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.led_index == $past(out_data.led_index) + 1'b1)
    else $error("LED sequence broken inside a frame");

  // No new time is taken while a frame is still being issued
  a_no_early_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s0.valid && !s0.last |-> !in_ready)
    else $error("input accepted mid-frame");
`endif

endmodule

[tb/clock_ring_frame_composer_test.sv]
// Self-checking testbench for the LED ring frame composer: random handshakes, frame predictor.
`timescale 1ns / 1ps

module clock_ring_frame_composer_test;
  import crfc_pkg::*;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int MINUTES_PER_STEP = RING_LEDS / FIVE_STEP;
  localparam int SETTLE_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  // Predictor state: register copy, frame being painted, expected LEDs
  cfg_t               face_cfg;
  logic [COLOR_W-1:0] frame_rgb [RING_LEDS];
  out_t               led_expect [$];
  out_t               want_led;
  in_t                time_queue [$];
  int                 mismatch_count = 0;

  // Sender and receiver pacing
  logic               in_taken = 1'b0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  logic [15:0]        ready_pattern = '1;
  int                 pattern_left = 0;
  int                 pattern_pos = 0;

  always #10 clk = ~clk;

  clock_ring_frame_composer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Divide each channel of a packed color by div
  function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] color,
                                                    input int div);
    logic [CH_W-1:0] r, g, b;
    r = CH_W'(color[23:16] / div);
    g = CH_W'(color[15:8] / div);
    b = CH_W'(color[7:0] / div);
    return {r, g, b};
  endfunction

  // OR one hand into the frame, tapering on both sides with wrap
  function automatic void paint_hand(input int centre, input logic [COLOR_W-1:0] color,
                                     input logic [SPREAD_W-1:0] lead_raw,
                                     input logic [SPREAD_W-1:0] trail_raw);
    int lead, trail;
    lead = (lead_raw > HAND_HALF_WIDTH) ? HAND_HALF_WIDTH : lead_raw;
    trail = (trail_raw > HAND_HALF_WIDTH) ? HAND_HALF_WIDTH : trail_raw;
    frame_rgb[centre] |= color;
    for (int d = 1; d <= lead; d++)
      frame_rgb[(centre + RING_LEDS - d) % RING_LEDS] |= dim_color(color, d);
    for (int d = 1; d <= trail; d++)
      frame_rgb[(centre + d) % RING_LEDS] |= dim_color(color, d + 1);
  endfunction

  // Build the 60 expected LEDs for one time of day
  function automatic void compose_frame(input in_t t);
    int hr, mn, sc, hour_pos;
    out_t led;
    hr = (t.hour > HOUR_MAX) ? HOUR_MAX : t.hour;
    mn = (t.minute > MINUTE_MAX) ? MINUTE_MAX : t.minute;
    sc = (t.second > MINUTE_MAX) ? MINUTE_MAX : t.second;
    hour_pos = (hr % HOURS_PER_FACE) * FIVE_STEP + mn / MINUTES_PER_STEP;
    for (int i = 0; i < RING_LEDS; i++) begin
      if (i % QUARTER_STEP == 0) frame_rgb[i] = face_cfg.quarter_color;
      else if (i % FIVE_STEP == 0) frame_rgb[i] = face_cfg.five_color;
      else frame_rgb[i] = '0;
    end
    paint_hand(hour_pos, face_cfg.hour_color, face_cfg.spreads[14:12],
               face_cfg.spreads[17:15]);
    paint_hand(mn, face_cfg.min_color, face_cfg.spreads[8:6], face_cfg.spreads[11:9]);
    paint_hand(sc, face_cfg.sec_color, face_cfg.spreads[2:0], face_cfg.spreads[5:3]);
    for (int i = 0; i < RING_LEDS; i++) begin
      led.led_index = LED_W'(i);
      led.red = frame_rgb[i][23:16];
      led.green = frame_rgb[i][15:8];
      led.blue = frame_rgb[i][7:0];
      led.last = (i == RING_LEDS - 1);
      led_expect.push_back(led);
    end
  endfunction

  function automatic in_t make_time(input int h, input int m, input int s);
    in_t t;
    t.hour = 5'(h);
    t.minute = LED_W'(m);
    t.second = LED_W'(s);
    return t;
  endfunction

  // Mostly legal times, some with hands bunched, some raw noise
  function automatic in_t random_time();
    in_t t;
    t = make_time($urandom_range(0, HOUR_MAX), $urandom_range(0, MINUTE_MAX),
                  $urandom_range(0, MINUTE_MAX));
    case ($urandom_range(0, 9))
      0: t = {5'($urandom), LED_W'($urandom), LED_W'($urandom)};
      1, 2: t.second = LED_W'((t.minute + $urandom_range(0, 8) + RING_LEDS - 4) % RING_LEDS);
      3: t.minute = LED_W'(((t.hour % HOURS_PER_FACE) * FIVE_STEP + $urandom_range(0, 6))
                           % RING_LEDS);
      default: ;
    endcase
    return t;
  endfunction

  // Write one register and mirror it into the predictor copy
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SEC_COLOR:     face_cfg.sec_color = data;
      CFG_MIN_COLOR:     face_cfg.min_color = data;
      CFG_HOUR_COLOR:    face_cfg.hour_color = data;
      CFG_SPREADS:       face_cfg.spreads = data[SPREADS_W-1:0];
      CFG_FIVE_COLOR:    face_cfg.five_color = data;
      CFG_QUARTER_COLOR: face_cfg.quarter_color = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_face(input logic [COLOR_W-1:0] sec, input logic [COLOR_W-1:0] mnt,
                          input logic [COLOR_W-1:0] hr, input logic [COLOR_W-1:0] spreads,
                          input logic [COLOR_W-1:0] five, input logic [COLOR_W-1:0] quarter);
    cfg_write(CFG_SEC_COLOR, sec);
    cfg_write(CFG_MIN_COLOR, mnt);
    cfg_write(CFG_HOUR_COLOR, hr);
    cfg_write(CFG_SPREADS, spreads);
    cfg_write(CFG_FIVE_COLOR, five);
    cfg_write(CFG_QUARTER_COLOR, quarter);
  endtask

  task automatic queue_random(input int n);
    repeat (n) time_queue.push_back(random_time());
  endtask

  // Hold until every time is taken and every LED has come out
  task automatic wait_idle();
    while (time_queue.size() != 0 || in_valid || led_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (time_queue.size() != 0) begin
        in_data <= time_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: cycle through a 16-bit ready pattern, swapped now and then
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(40, 300);
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = ~(16'h1 << $urandom_range(0, 15));
        default: ready_pattern = 16'($urandom) & 16'($urandom);
      endcase
      if (ready_pattern == '0) ready_pattern = 16'h0001;
    end
    pattern_left--;
    out_ready <= ready_pattern[pattern_pos];
    pattern_pos = (pattern_pos + 1) % 16;
  end

  // Monitor: predict on accepted times, check each accepted LED
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) compose_frame(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (led_expect.size() == 0) begin
        report_mismatch($sformatf("LED %0d with no frame pending", out_data.led_index));
      end else begin
        want_led = led_expect.pop_front();
        if (out_data.led_index !== want_led.led_index)
          report_mismatch($sformatf("led_index %0d, want %0d",
                                    out_data.led_index, want_led.led_index));
        if (out_data.red !== want_led.red)
          report_mismatch($sformatf("LED %0d red %0h, want %0h",
                                    want_led.led_index, out_data.red, want_led.red));
        if (out_data.green !== want_led.green)
          report_mismatch($sformatf("LED %0d green %0h, want %0h",
                                    want_led.led_index, out_data.green, want_led.green));
        if (out_data.blue !== want_led.blue)
          report_mismatch($sformatf("LED %0d blue %0h, want %0h",
                                    want_led.led_index, out_data.blue, want_led.blue));
        if (out_data.last !== want_led.last)
          report_mismatch($sformatf("LED %0d last %b, want %b",
                                    want_led.led_index, out_data.last, want_led.last));
      end
    end
  end

  // Stimulus: phases of register settings, each drained before the next
  initial begin
    face_cfg = '{sec_color: 24'h0A0000, min_color: 24'h000A00, hour_color: 24'h00000F,
                 spreads: 18'd74304, five_color: 24'h010101, quarter_color: 24'h020200};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Undecoded indexes must leave the defaults alone
    cfg_write(CFG_SPARE_LO, 24'($urandom));
    cfg_write(CFG_SPARE_HI, 24'($urandom));

    // Defaults: overlap, wrap, saturation, hour on the twelve
    time_queue.push_back(make_time(0, 0, 0));
    time_queue.push_back(make_time(23, 59, 59));
    time_queue.push_back(make_time(31, 63, 63));
    time_queue.push_back(make_time(24, 60, 60));
    time_queue.push_back(make_time(12, 0, 30));
    time_queue.push_back(make_time(11, 59, 0));
    time_queue.push_back(make_time(3, 15, 45));
    time_queue.push_back(make_time(6, 36, 1));
    time_queue.push_back(make_time(9, 11, 58));
    time_queue.push_back(make_time(17, 48, 13));
    time_queue.push_back(make_time(5, 27, 5));
    time_queue.push_back(make_time(0, 12, 14));
    queue_random(30);
    wait_idle();

    // Full colors, every spread above the clamp
    set_face('1, '1, '1, COLOR_W'((1 << SPREADS_W) - 1), '1, '1);
    time_queue.push_back(make_time(0, 0, 0));
    time_queue.push_back(make_time(23, 59, 59));
    time_queue.push_back(make_time(31, 63, 63));
    time_queue.push_back(make_time(7, 35, 22));
    time_queue.push_back(make_time(2, 10, 30));
    time_queue.push_back(make_time(16, 44, 50));
    queue_random(30);
    wait_idle();

    // Dark face, no spread
    set_face('0, '0, '0, '0, '0, '0);
    queue_random(20);
    wait_idle();

    // Spreads exactly at the clamp, random colors
    set_face(24'($urandom), 24'($urandom), 24'($urandom), 24'h024924,
             24'($urandom), 24'($urandom));
    queue_random(30);
    wait_idle();

    // Random settings
    repeat (5) begin
      set_face(24'($urandom), 24'($urandom), 24'($urandom),
               24'($urandom_range(0, (1 << SPREADS_W) - 1)), 24'($urandom), 24'($urandom));
      queue_random(30);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
